FILE: hw/rtl/necir_pkg.sv
// ----------------------------------------------------------------------------
// necir_pkg
// Shared widths, timing windows and types for the NEC infrared frame decoder.
// ----------------------------------------------------------------------------
package necir_pkg;

  // field widths
  localparam int unsigned DurW   = 18;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned FrameW = 32;
  localparam int unsigned CountW = $clog2(FrameW);

  typedef logic [DurW-1:0]  dur_t;
  typedef logic [ByteW-1:0] byte_t;

  // leader window, inclusive bounds
  localparam dur_t LeadMarkMin  = DurW'(8000);
  localparam dur_t LeadMarkMax  = DurW'(10000);
  localparam dur_t LeadSpaceMin = DurW'(1500);
  localparam dur_t LeadSpaceMax = DurW'(5500);
  // leader spaces below this are repeat codes
  localparam dur_t RepeatSpaceLim = DurW'(3500);

  // data mark window, inclusive bounds
  localparam dur_t BitMarkMin = DurW'(460);
  localparam dur_t BitMarkMax = DurW'(660);
  // data space windows, exclusive bounds
  localparam dur_t ZeroSpaceLo = DurW'(460);
  localparam dur_t ZeroSpaceHi = DurW'(660);
  localparam dur_t OneSpaceLo  = DurW'(1590);
  localparam dur_t OneSpaceHi  = DurW'(1790);

  // result kinds
  localparam logic KindFrame  = 1'b0;
  localparam logic KindRepeat = 1'b1;

  // classification of one mark/space pair
  typedef struct packed {
    logic lead_ok;      // mark and space both fit the leader
    logic lead_repeat;  // leader space is short: repeat code
    logic data_mark_ok; // mark fits a data bit
    logic space_zero;   // space encodes a 0
    logic space_one;    // space encodes a 1
  } pair_class_t;

endpackage

FILE: hw/rtl/necir_if.sv
// ----------------------------------------------------------------------------
// necir_if
// Valid/ready channels: measured pairs in, decoded results out.
// ----------------------------------------------------------------------------
interface necir_pair_if;
  logic                       valid;
  logic                       ready;
  logic [necir_pkg::DurW-1:0] mark_us;
  logic [necir_pkg::DurW-1:0] space_us;

  modport source (output valid, output mark_us, output space_us, input ready);
  modport sink   (input valid, input mark_us, input space_us, output ready);
endinterface

interface necir_result_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [necir_pkg::ByteW-1:0] address;
  logic [necir_pkg::ByteW-1:0] command;

  modport source (output valid, output kind, output address, output command, input ready);
  modport sink   (input valid, input kind, input address, input command, output ready);
endinterface

FILE: hw/rtl/necir_pair_class.sv
// ----------------------------------------------------------------------------
// necir_pair_class
// Window compares that classify one registered mark/space pair.
// ----------------------------------------------------------------------------
module necir_pair_class (
  input  necir_pkg::dur_t        mark_i,
  input  necir_pkg::dur_t        space_i,
  output necir_pkg::pair_class_t class_o
);
  import necir_pkg::*;

  // leader checks
  assign class_o.lead_ok = (mark_i >= LeadMarkMin) && (mark_i <= LeadMarkMax) &&
                           (space_i >= LeadSpaceMin) && (space_i <= LeadSpaceMax);
  assign class_o.lead_repeat = (space_i < RepeatSpaceLim);

  // data bit checks
  assign class_o.data_mark_ok = (mark_i >= BitMarkMin) && (mark_i <= BitMarkMax);
  assign class_o.space_zero   = (space_i > ZeroSpaceLo) && (space_i < ZeroSpaceHi);
  assign class_o.space_one    = (space_i > OneSpaceLo) && (space_i < OneSpaceHi);

endmodule

FILE: hw/rtl/necir_frame_fsm.sv
// ----------------------------------------------------------------------------
// necir_frame_fsm
// Frame state, bit collection, frame check and the result register.
// ----------------------------------------------------------------------------
module necir_frame_fsm (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  necir_pkg::pair_class_t class_i,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic                   kind_o,
  output necir_pkg::byte_t       address_o,
  output necir_pkg::byte_t       command_o
);
  import necir_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StData = 1'b1;

  logic              state_q, state_d;
  logic [CountW-1:0] count_q, count_d;
  logic [FrameW-1:0] frame_q, frame_d;
  byte_t             last_addr_q, last_addr_d;
  byte_t             last_cmd_q, last_cmd_d;
  logic              out_valid_q, out_valid_d;
  logic              kind_q, kind_d;
  byte_t             addr_q, addr_d;
  byte_t             cmd_q, cmd_d;

  logic              bit_ok;
  logic [FrameW-1:0] frame_full;
  byte_t             b0, b1, b2, b3;
  logic              check_ok;

  // a completed frame: newest bit enters at the top, first bit ends at bit 0
  assign bit_ok     = class_i.data_mark_ok && (class_i.space_zero || class_i.space_one);
  assign frame_full = {class_i.space_one, frame_q[FrameW-1:1]};
  assign b0         = frame_full[ByteW-1:0];
  assign b1         = frame_full[2*ByteW-1:ByteW];
  assign b2         = frame_full[3*ByteW-1:2*ByteW];
  assign b3         = frame_full[4*ByteW-1:3*ByteW];
  assign check_ok   = ((b0 ^ b1) == '1) && ((b2 ^ b3) == '1);

  // next state and result
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    frame_d     = frame_q;
    last_addr_d = last_addr_q;
    last_cmd_d  = last_cmd_q;
    out_valid_d = out_valid_q && !out_ready_i;
    kind_d      = kind_q;
    addr_d      = addr_q;
    cmd_d       = cmd_q;
    if (step_i) begin
      case (state_q)
        StIdle: begin
          if (class_i.lead_ok) begin
            if (class_i.lead_repeat) begin
              out_valid_d = 1'b1;
              kind_d      = KindRepeat;
              addr_d      = last_addr_q;
              cmd_d       = last_cmd_q;
            end else begin
              state_d = StData;
              count_d = '0;
              frame_d = '0;
            end
          end
        end
        StData: begin
          if (!bit_ok) begin
            state_d = StIdle;
          end else begin
            frame_d = frame_full;
            count_d = count_q + 1'b1;
            // last bit of the frame
            if (count_q == CountW'(FrameW - 1)) begin
              state_d = StIdle;
              if (check_ok) begin
                last_addr_d = b0;
                last_cmd_d  = b2;
                out_valid_d = 1'b1;
                kind_d      = KindFrame;
                addr_d      = b0;
                cmd_d       = b2;
              end
            end
          end
        end
        default: begin
          state_d = StIdle;
        end
      endcase
    end
  end

  // control and stored bytes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      frame_q     <= '0;
      last_addr_q <= '0;
      last_cmd_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      frame_q     <= frame_d;
      last_addr_q <= last_addr_d;
      last_cmd_q  <= last_cmd_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    addr_q <= addr_d;
    cmd_q  <= cmd_d;
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign address_o   = addr_q;
  assign command_o   = cmd_q;

endmodule

FILE: hw/rtl/nec_ir_frame_decoder.sv
// ----------------------------------------------------------------------------
// nec_ir_frame_decoder
// NEC infrared remote decoder working on measured mark/space pairs.
// ----------------------------------------------------------------------------
// Each transaction on pair_i carries one mark/space pair in microseconds.
// A leader with a short space answers with a repeat result (kind 1) holding
// the last decoded address and command; a leader with a long space starts a
// 32-bit frame, and a frame whose address and command match their inverted
// copies yields one result (kind 0). Malformed pairs end a frame silently.
// The decoder takes one pair per clock cycle while no result waits on
// result_o.ready. A pair is first held in the input register and is then
// decoded into the result register, which presents the result on result_o.
// While a result waits on result_o.ready, the pair behind it stays in the
// input register and pair_i.ready drops until the result is taken.
module nec_ir_frame_decoder (
  input  logic            clk_i,
  input  logic            rst_ni,
  necir_pair_if.sink      pair_i,
  necir_result_if.source  result_o
);
  import necir_pkg::*;

  logic        in_valid_q, in_valid_d;
  dur_t        mark_q, space_q;
  logic        in_take;
  logic        advance;
  logic        out_valid;
  pair_class_t pair_class;

  // input register moves on whenever the result register can take a result
  assign advance      = in_valid_q && (!out_valid || result_o.ready);
  assign pair_i.ready = !in_valid_q || advance;
  assign in_take      = pair_i.valid && pair_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      mark_q  <= pair_i.mark_us;
      space_q <= pair_i.space_us;
    end
  end

  // pair classification
  necir_pair_class u_class (
    .mark_i  (mark_q),
    .space_i (space_q),
    .class_o (pair_class)
  );

  // frame tracking and result register
  necir_frame_fsm u_fsm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .class_i     (pair_class),
    .out_ready_i (result_o.ready),
    .out_valid_o (out_valid),
    .kind_o      (result_o.kind),
    .address_o   (result_o.address),
    .command_o   (result_o.command)
  );

  assign result_o.valid = out_valid;

endmodule
